// ----- design/rotated_rect_placement_fitness_defines.svh -----
// -----------------------------------------------------------------------------
// Assertion macros for the rotated rectangle placement fitness block
// Concurrent checks on i_clk, masked while i_rst_n is low.
// -----------------------------------------------------------------------------
`ifndef ROTATED_RECT_PLACEMENT_FITNESS_DEFINES_SVH
`define ROTATED_RECT_PLACEMENT_FITNESS_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define RRPF_CHECK(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("rrpf check failed");
`define RRPF_CHECK_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) pre |=> post) \
        else $error("rrpf next-cycle check failed");
`else
`define RRPF_CHECK(lbl, prop)
`define RRPF_CHECK_NEXT(lbl, pre, post)
`endif

`endif

// ----- design/rrpf_pkg.sv -----
// -----------------------------------------------------------------------------
// rrpf_pkg
// Types, widths, register indexes and the sine table of the placement scorer.
// -----------------------------------------------------------------------------
package rrpf_pkg;

    localparam int MAX_OBSTACLES = 4;

    localparam int CW  = 16;          // Q8.8 coordinate / size
    localparam int PW  = 18;          // corner coordinate
    localparam int EW  = 19;          // edge vector component
    localparam int MW  = PW + EW;     // one projection product
    localparam int SW  = MW + 1;      // projection sum
    localparam int BW  = 20;          // doubled containment bounds

    localparam logic [2:0] CFG_CCX   = 3'd0;
    localparam logic [2:0] CFG_CCY   = 3'd1;
    localparam logic [2:0] CFG_CW    = 3'd2;
    localparam logic [2:0] CFG_CH    = 3'd3;
    localparam logic [2:0] CFG_COUNT = 3'd4;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    typedef struct packed {
        logic                  operation;
        logic [1:0]            slot;
        logic signed [CW-1:0]  center_x;
        logic signed [CW-1:0]  center_y;
        logic signed [CW-1:0]  width;
        logic signed [CW-1:0]  height;
        logic [15:0]           angle;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] fitness;
        logic               inside_res;
        logic               overlaps;
    } t_out_item;

    typedef struct packed {
        logic [15:0]           angle;
        logic signed [CW-1:0]  center_x;
        logic signed [CW-1:0]  center_y;
        logic signed [CW-1:0]  width;
        logic signed [CW-1:0]  height;
    } t_obst;

    // Q2.14 sine, first quarter turn, 64 steps plus the end point
    localparam logic [14:0] SIN_Q [65] = '{
        15'd0,     15'd402,   15'd804,   15'd1205,  15'd1606,  15'd2006,  15'd2404,
        15'd2801,  15'd3196,  15'd3590,  15'd3981,  15'd4370,  15'd4756,  15'd5139,
        15'd5520,  15'd5897,  15'd6270,  15'd6639,  15'd7005,  15'd7366,  15'd7723,
        15'd8076,  15'd8423,  15'd8765,  15'd9102,  15'd9434,  15'd9760,  15'd10080,
        15'd10394, 15'd10702, 15'd11003, 15'd11297, 15'd11585, 15'd11866, 15'd12140,
        15'd12406, 15'd12665, 15'd12916, 15'd13160, 15'd13395, 15'd13623, 15'd13842,
        15'd14053, 15'd14256, 15'd14449, 15'd14635, 15'd14811, 15'd14978, 15'd15137,
        15'd15286, 15'd15426, 15'd15557, 15'd15679, 15'd15791, 15'd15893, 15'd15986,
        15'd16069, 15'd16143, 15'd16207, 15'd16261, 15'd16305, 15'd16340, 15'd16364,
        15'd16379, 15'd16384
    };

    function automatic logic signed [15:0] sin_step(input logic [7:0] idx);
        logic [5:0]         k;
        logic [14:0]        v;
        logic signed [15:0] sv;
        k  = idx[5:0];
        v  = idx[6] ? SIN_Q[7'd64 - {1'b0, k}] : SIN_Q[{1'b0, k}];
        sv = signed'({1'b0, v});
        return idx[7] ? -sv : sv;
    endfunction

endpackage

// ----- design/rrpf_ram.sv -----
// -----------------------------------------------------------------------------
// rrpf_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// -----------------------------------------------------------------------------
module rrpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- design/rotated_rect_placement_fitness.sv -----
// -----------------------------------------------------------------------------
// rotated_rect_placement_fitness
// Load: taken while idle, busy stays low. Evaluate: result strobe after the
// candidate's corners and containment, then per active obstacle a shared corner
// multiplier pass and up to 4 axes x 9 projection steps; one at a time.
// Synchronous active-low reset idles the sequencer and restores the container
// registers; obstacle slots hold nothing until loaded.
// -----------------------------------------------------------------------------
`include "rotated_rect_placement_fitness_defines.svh"

module rotated_rect_placement_fitness #(
    parameter int MAX_OBSTACLES = rrpf_pkg::MAX_OBSTACLES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  rrpf_pkg::t_in_item  i_item,
    output logic                o_strobe,
    output rrpf_pkg::t_out_item o_result,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);

    localparam int AW  = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
    localparam int NCW = $clog2(MAX_OBSTACLES + 1);
    localparam int CW  = rrpf_pkg::CW;
    localparam int PW  = rrpf_pkg::PW;
    localparam int EW  = rrpf_pkg::EW;
    localparam int MW  = rrpf_pkg::MW;
    localparam int SW  = rrpf_pkg::SW;
    localparam int BW  = rrpf_pkg::BW;
    localparam int OW  = $bits(rrpf_pkg::t_obst);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL  = 4'd1;
    localparam logic [3:0] S_CORN = 4'd2;
    localparam logic [3:0] S_CONT = 4'd3;
    localparam logic [3:0] S_NEXT = 4'd4;
    localparam logic [3:0] S_LDOB = 4'd5;
    localparam logic [3:0] S_AXIS = 4'd6;
    localparam logic [3:0] S_PROJ = 4'd7;
    localparam logic [3:0] S_CMP  = 4'd8;

    // configuration
    logic signed [15:0] r_ccx, r_ccy;
    logic [14:0]        r_ccw, r_cch;
    logic [2:0]         r_ocnt;

    // sequencer
    logic [3:0]     r_state;
    logic [1:0]     r_k;
    logic           r_obmode;
    logic [NCW-1:0] r_obi;
    logic [1:0]     r_ax;
    logic [3:0]     r_step;

    // rectangle being expanded into corners
    logic signed [CW-1:0] r_scx, r_scy, r_sw, r_sh;
    logic signed [15:0]   r_sin, r_cos;
    logic signed [15:0]   r_t [4];

    logic signed [CW-1:0] r_cw, r_ch;
    logic signed [31:0]   r_fit;
    logic signed [PW-1:0] r_px [4];
    logic signed [PW-1:0] r_py [4];
    logic signed [PW-1:0] r_qx [4];
    logic signed [PW-1:0] r_qy [4];
    logic                 r_inside, r_hit;

    logic signed [EW-1:0] r_nx, r_ny;
    logic signed [MW-1:0] r_mx, r_my;
    logic signed [SW-1:0] r_lo1, r_hi1, r_lo2, r_hi2;

    logic                r_strobe;
    rrpf_pkg::t_out_item r_out;

    // obstacle memory
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    rrpf_pkg::t_obst  ram_wdata;
    logic [OW-1:0]    ram_rdata;
    rrpf_pkg::t_obst  ob_rd;

    logic                 in_xfer;
    logic [NCW-1:0]       n_eff;
    logic signed [15:0]   mul_a, mul_b;
    logic signed [31:0]   mul_p;
    logic signed [PW-1:0] c_x [4];
    logic signed [PW-1:0] c_y [4];
    logic                 c_inside;
    logic signed [PW-1:0] e_xa, e_xb, e_ya, e_yb;
    logic signed [PW-1:0] s_x, s_y;
    logic signed [SW-1:0] proj;
    logic [2:0]           j;
    logic                 sep;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_strobe    = r_strobe;
    assign o_result    = r_out;
    assign in_xfer     = start && !busy;

    assign ram_we    = in_xfer && (i_item.operation == rrpf_pkg::OP_LOAD) &&
                       (int'(i_item.slot) < MAX_OBSTACLES);
    assign ram_waddr = AW'(i_item.slot);
    assign ram_wdata = '{angle: i_item.angle, center_x: i_item.center_x,
                         center_y: i_item.center_y, width: i_item.width,
                         height: i_item.height};
    assign ob_rd     = rrpf_pkg::t_obst'(ram_rdata);

    rrpf_ram #(
        .WIDTH (OW),
        .DEPTH (MAX_OBSTACLES),
        .AW    (AW)
    ) u_obst_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_obi[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign n_eff = (int'(r_ocnt) > MAX_OBSTACLES) ? NCW'(MAX_OBSTACLES) : NCW'(r_ocnt);

    // shared half-extent multiplier: k = 0..3 gives w*cos, w*sin, h*cos, h*sin
    assign mul_a = r_k[1] ? r_sh : r_sw;
    assign mul_b = r_k[0] ? r_sin : r_cos;
    assign mul_p = mul_a * mul_b;

    always_comb begin
        logic signed [PW-1:0] cx, cy, a, b, d, e;
        cx = PW'(r_scx);
        cy = PW'(r_scy);
        a  = PW'(r_t[0]);
        b  = PW'(r_t[1]);
        d  = PW'(r_t[2]);
        e  = PW'(r_t[3]);
        c_x[0] = cx - a + e;  c_y[0] = cy - b - d;
        c_x[1] = cx + a + e;  c_y[1] = cy + b - d;
        c_x[2] = cx + a - e;  c_y[2] = cy + b + d;
        c_x[3] = cx - a - e;  c_y[3] = cy - b + d;
    end

    // containment on doubled values, boundary counts as inside
    always_comb begin
        logic signed [BW-1:0] lx, hx, ly, hy, px2, py2;
        lx = (BW'(r_ccx) <<< 1) - signed'(BW'(r_ccw));
        hx = (BW'(r_ccx) <<< 1) + signed'(BW'(r_ccw));
        ly = (BW'(r_ccy) <<< 1) - signed'(BW'(r_cch));
        hy = (BW'(r_ccy) <<< 1) + signed'(BW'(r_cch));
        c_inside = 1'b1;
        for (int i = 0; i < 4; i++) begin
            px2 = BW'(r_px[i]) <<< 1;
            py2 = BW'(r_py[i]) <<< 1;
            if (px2 < lx || px2 > hx || py2 < ly || py2 > hy) begin
                c_inside = 1'b0;
            end
        end
    end

    // edge endpoints: axes 0,1 from the candidate, 2,3 from the obstacle
    always_comb begin
        if (!r_ax[1]) begin
            e_xa = r_ax[0] ? r_px[1] : r_px[0];
            e_xb = r_ax[0] ? r_px[2] : r_px[1];
            e_ya = r_ax[0] ? r_py[1] : r_py[0];
            e_yb = r_ax[0] ? r_py[2] : r_py[1];
        end else begin
            e_xa = r_ax[0] ? r_qx[1] : r_qx[0];
            e_xb = r_ax[0] ? r_qx[2] : r_qx[1];
            e_ya = r_ax[0] ? r_qy[1] : r_qy[0];
            e_yb = r_ax[0] ? r_qy[2] : r_qy[1];
        end
    end

    assign s_x  = r_step[2] ? r_qx[r_step[1:0]] : r_px[r_step[1:0]];
    assign s_y  = r_step[2] ? r_qy[r_step[1:0]] : r_py[r_step[1:0]];
    assign proj = SW'(r_mx) + SW'(r_my);
    assign j    = 3'(r_step - 4'd1);
    assign sep  = (r_hi1 < r_lo2) || (r_hi2 < r_lo1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ccx    <= 16'sd1280;
            r_ccy    <= 16'sd1024;
            r_ccw    <= 15'd2560;
            r_cch    <= 15'd2048;
            r_ocnt   <= 3'd0;
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    rrpf_pkg::CFG_CCX:   r_ccx  <= signed'(i_cfg_data);
                    rrpf_pkg::CFG_CCY:   r_ccy  <= signed'(i_cfg_data);
                    rrpf_pkg::CFG_CW:    r_ccw  <= i_cfg_data[14:0];
                    rrpf_pkg::CFG_CH:    r_cch  <= i_cfg_data[14:0];
                    rrpf_pkg::CFG_COUNT: r_ocnt <= i_cfg_data[2:0];
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (in_xfer && i_item.operation == rrpf_pkg::OP_EVAL) begin
                        r_scx    <= i_item.center_x;
                        r_scy    <= i_item.center_y;
                        r_sw     <= i_item.width;
                        r_sh     <= i_item.height;
                        r_cw     <= i_item.width;
                        r_ch     <= i_item.height;
                        r_sin    <= rrpf_pkg::sin_step(i_item.angle[15:8]);
                        r_cos    <= rrpf_pkg::sin_step(8'(i_item.angle[15:8] + 8'd64));
                        r_obmode <= 1'b0;
                        r_k      <= 2'd0;
                        r_obi    <= '0;
                        r_hit    <= 1'b0;
                        r_state  <= S_MUL;
                    end
                end
                S_MUL: begin
                    // floor of the Q2.14 product shifted by 15
                    r_t[r_k] <= mul_p[30:15];
                    r_k      <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        r_state <= S_CORN;
                    end
                end
                S_CORN: begin
                    if (!r_obmode) begin
                        r_px    <= c_x;
                        r_py    <= c_y;
                        r_fit   <= r_cw * r_ch;
                        r_state <= S_CONT;
                    end else begin
                        r_qx    <= c_x;
                        r_qy    <= c_y;
                        r_ax    <= 2'd0;
                        r_state <= S_AXIS;
                    end
                end
                S_CONT: begin
                    r_inside <= c_inside;
                    r_state  <= S_NEXT;
                end
                S_NEXT: begin
                    if (r_obi < n_eff) begin
                        r_state <= S_LDOB;
                    end else begin
                        r_strobe         <= 1'b1;
                        r_out.fitness    <= (r_inside && !r_hit) ? r_fit : 32'sd0;
                        r_out.inside_res <= r_inside;
                        r_out.overlaps   <= r_hit;
                        r_state          <= S_IDLE;
                    end
                end
                S_LDOB: begin
                    r_scx    <= ob_rd.center_x;
                    r_scy    <= ob_rd.center_y;
                    r_sw     <= ob_rd.width;
                    r_sh     <= ob_rd.height;
                    r_sin    <= rrpf_pkg::sin_step(ob_rd.angle[15:8]);
                    r_cos    <= rrpf_pkg::sin_step(8'(ob_rd.angle[15:8] + 8'd64));
                    r_obmode <= 1'b1;
                    r_k      <= 2'd0;
                    r_state  <= S_MUL;
                end
                S_AXIS: begin
                    // normal of the edge: (-(dy), dx)
                    r_nx    <= EW'(e_ya) - EW'(e_yb);
                    r_ny    <= EW'(e_xb) - EW'(e_xa);
                    r_step  <= 4'd0;
                    r_state <= S_PROJ;
                end
                S_PROJ: begin
                    // products for corner step, sum of the previous corner's pair
                    r_mx <= MW'(s_x) * MW'(r_nx);
                    r_my <= MW'(s_y) * MW'(r_ny);
                    if (r_step != 4'd0) begin
                        if (!j[2]) begin
                            if (j[1:0] == 2'd0) begin
                                r_lo1 <= proj;
                                r_hi1 <= proj;
                            end else begin
                                if (proj < r_lo1) r_lo1 <= proj;
                                if (proj > r_hi1) r_hi1 <= proj;
                            end
                        end else begin
                            if (j[1:0] == 2'd0) begin
                                r_lo2 <= proj;
                                r_hi2 <= proj;
                            end else begin
                                if (proj < r_lo2) r_lo2 <= proj;
                                if (proj > r_hi2) r_hi2 <= proj;
                            end
                        end
                    end
                    r_step <= r_step + 4'd1;
                    if (r_step == 4'd8) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (sep) begin
                        r_obi   <= r_obi + NCW'(1);
                        r_state <= S_NEXT;
                    end else if (r_ax == 2'd3) begin
                        r_hit   <= 1'b1;
                        r_obi   <= r_obi + NCW'(1);
                        r_state <= S_NEXT;
                    end else begin
                        r_ax    <= r_ax + 2'd1;
                        r_state <= S_AXIS;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `RRPF_CHECK(a_strobe_idle, o_strobe |-> !busy)
    `RRPF_CHECK_NEXT(a_strobe_single, o_strobe, !o_strobe)
    `RRPF_CHECK_NEXT(a_load_no_busy, in_xfer && i_item.operation == rrpf_pkg::OP_LOAD, !busy)
    `RRPF_CHECK(a_reject_zero, o_strobe && (o_result.overlaps || !o_result.inside_res) |-> o_result.fitness == 32'sd0)

endmodule
